[hw/rtl/cses_pkg.sv]
`default_nettype none
package cses_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 3;
  localparam int MAX_ENTRIES   = 8;
  localparam int CFG_IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_W       = 64;
  localparam int IDX_W         = 3;

  // packing of one table entry word
  localparam int ID_W       = 29;
  localparam int START_LSB  = 29;
  localparam int START_W    = 3;
  localparam int LENC_LSB   = 32;
  localparam int LENC_W     = 2;
  localparam int SCALE_LSB  = 34;
  localparam int SCALE_W    = 20;
  localparam int OFFSET_LSB = 54;
  localparam int OFFSET_W   = 10;

  // fixed point
  localparam int FRAC_W = 16;
  localparam int RAW_W  = 32;
  localparam int PROD_W = RAW_W + SCALE_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int QUO_W  = SUM_W - FRAC_W;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 32;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ENTRY_W-1:0] ENTRY_RESET [MAX_ENTRIES] = '{
    64'h0001000200000100, 64'hF604000140000101, 64'h0000666A80000102,
    64'h0, 64'h0, 64'h0, 64'h0, 64'h0
  };

  typedef enum logic [1:0] {
    ST_ROUTED    = 2'd0,
    ST_NO_MATCH  = 2'd1,
    ST_DLC_SHORT = 2'd2,
    ST_CLEARED   = 2'd3
  } status_t;

  typedef enum logic [LENC_W-1:0] {
    LEN_NONE = 2'd0,
    LEN_ONE  = 2'd1,
    LEN_TWO  = 2'd2,
    LEN_FOUR = 2'd3
  } lencode_t;

  // classified request handed from front to back
  typedef struct packed {
    status_t                     status;
    logic [IDX_W-1:0]            idx;
    logic [RAW_W-1:0]            raw;
    logic [SCALE_W-1:0]          scale;
    logic signed [OFFSET_W-1:0]  offset;
  } job_t;

  // byte count of a length code
  function automatic logic [2:0] len_bytes(input lencode_t lc);
    logic [2:0] n;
    unique case (lc)
      LEN_NONE: n = 3'd0;
      LEN_ONE:  n = 3'd1;
      LEN_TWO:  n = 3'd2;
      LEN_FOUR: n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // mask for the raw value of a length code
  function automatic logic [RAW_W-1:0] len_mask(input lencode_t lc);
    logic [RAW_W-1:0] m;
    unique case (lc)
      LEN_NONE: m = 32'h0000_0000;
      LEN_ONE:  m = 32'h0000_00FF;
      LEN_TWO:  m = 32'h0000_FFFF;
      LEN_FOUR: m = 32'hFFFF_FFFF;
      default:  m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cses_if.sv]
`default_nettype none
// frame channel
interface cses_frame_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [28:0] frame_id;
  logic [3:0]  frame_dlc;
  logic [63:0] frame_data;

  modport source (output valid, action, frame_id, frame_dlc, frame_data, input ready);
  modport sink   (input valid, action, frame_id, frame_dlc, frame_data, output ready);
endinterface

// result channel
interface cses_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         signal_index;
  logic signed [31:0] scaled_value;
  logic [31:0]        count_processed;
  logic [31:0]        count_dropped;
  logic [31:0]        count_routed;

  modport source (output valid, status, signal_index, scaled_value, count_processed,
                  count_dropped, count_routed, input ready);
  modport sink   (input valid, status, signal_index, scaled_value, count_processed,
                  count_dropped, count_routed, output ready);
endinterface
`default_nettype wire

[hw/rtl/can_signal_extract_scale_unit.sv]
`default_nettype none
// CAN signal extraction with linear scaling. Each frame request is matched against the
// signal table (lowest matching entry wins), its raw value is taken little-endian from
// the data bytes, and routed values come out as raw * scale + offset in Q16, rounded
// by adding one half, truncated toward zero and saturated to signed 32 bits, together
// with the processed, dropped and routed counters. One frame is accepted per clock
// cycle; the request is classified and written into a two-entry queue at the accepting
// edge, then passes one multiply stage and the offset/saturate stage into the output
// register. The front stalls only when the queue is full, which happens only while the
// output is held. Table entries reset to their defaults at once; no clearing pass.
module can_signal_extract_scale_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cses_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cses_pkg::ENTRY_W-1:0]   cfg_data,
  cses_frame_if.sink                          frame_ch,
  cses_result_if.source                       result_ch
);

  logic           push;
  logic           pop;
  logic           full;
  logic           head_valid;
  cses_pkg::job_t wr_job;
  cses_pkg::job_t head;

  cses_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .frame_ch   (frame_ch),
    .queue_full (full),
    .push       (push),
    .job        (wr_job)
  );

  cses_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (wr_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  cses_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result_ch  (result_ch)
  );

endmodule
`default_nettype wire

[hw/rtl/cses_front.sv]
`default_nettype none
module cses_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cses_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cses_pkg::ENTRY_W-1:0]   cfg_data,
  cses_frame_if.sink                         frame_ch,
  input  wire logic                          queue_full,
  output logic                               push,
  output cses_pkg::job_t                     job
);

  logic [cses_pkg::ENTRY_W-1:0] entry [cses_pkg::TABLE_ENTRIES];

  // hold the signal table; out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cses_pkg::TABLE_ENTRIES; i++) begin
        entry[i] <= cses_pkg::ENTRY_RESET[i];
      end
    end else if (cfg_we) begin
      for (int i = 0; i < cses_pkg::TABLE_ENTRIES; i++) begin
        if (32'(cfg_index) == i) begin
          entry[i] <= cfg_data;
        end
      end
    end
  end

  assign frame_ch.ready = !queue_full;
  assign push           = frame_ch.valid && !queue_full;

  logic                           found;
  logic [cses_pkg::IDX_W-1:0]     hit_idx;
  logic [cses_pkg::ENTRY_W-1:0]   hit_word;
  logic [cses_pkg::START_W-1:0]   start;
  cses_pkg::lencode_t             lc;
  logic [4:0]                     need;
  logic [63:0]                    shifted;

  // match the identifier; the lowest entry wins
  always_comb begin
    found    = 1'b0;
    hit_idx  = '0;
    hit_word = '0;
    for (int i = cses_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (entry[i][cses_pkg::ID_W-1:0] == frame_ch.frame_id) begin
        found    = 1'b1;
        hit_idx  = cses_pkg::IDX_W'(i);
        hit_word = entry[i];
      end
    end
  end

  // extract the raw value and classify the request
  always_comb begin
    start   = hit_word[cses_pkg::START_LSB +: cses_pkg::START_W];
    lc      = cses_pkg::lencode_t'(hit_word[cses_pkg::LENC_LSB +: cses_pkg::LENC_W]);
    need    = {2'b00, start} + {2'b00, cses_pkg::len_bytes(lc)};
    shifted = frame_ch.frame_data >> {start, 3'b000};

    job.raw    = shifted[cses_pkg::RAW_W-1:0] & cses_pkg::len_mask(lc);
    job.scale  = hit_word[cses_pkg::SCALE_LSB +: cses_pkg::SCALE_W];
    job.offset = hit_word[cses_pkg::OFFSET_LSB +: cses_pkg::OFFSET_W];
    job.idx    = found ? hit_idx : '0;
    priority if (frame_ch.action) begin
      job.status = cses_pkg::ST_CLEARED;
      job.idx    = '0;
    end else if (!found) begin
      job.status = cses_pkg::ST_NO_MATCH;
    end else if ({1'b0, frame_ch.frame_dlc} < need) begin
      job.status = cses_pkg::ST_DLC_SHORT;
    end else begin
      job.status = cses_pkg::ST_ROUTED;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cses_queue.sv]
`default_nettype none
module cses_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cses_pkg::job_t wr_job,
  input  wire logic  pop,
  output logic       full,
  output logic       head_valid,
  output cses_pkg::job_t head
);

  cses_pkg::job_t                slot [cses_pkg::QUEUE_DEPTH];
  logic [cses_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cses_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cses_pkg::QCNT_W-1:0]   count;

  assign full       = (count == cses_pkg::QCNT_W'(cses_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slot[rd_ptr];

  // store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_job;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cses_pkg::QPTR_W'(cses_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cses_pkg::QPTR_W'(cses_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cses_back.sv]
`default_nettype none
module cses_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  wire cses_pkg::job_t head,
  output logic           pop,
  cses_result_if.source  result_ch
);

  // multiply stage
  logic                              s1_valid;
  cses_pkg::status_t                 s1_status;
  logic [cses_pkg::IDX_W-1:0]        s1_idx;
  logic signed [cses_pkg::OFFSET_W-1:0] s1_offset;
  logic [cses_pkg::PROD_W-1:0]       s1_prod;

  logic out_load;
  logic s1_load;

  assign out_load = s1_valid && (!result_ch.valid || result_ch.ready);
  assign s1_load  = !s1_valid || out_load;
  assign pop      = head_valid && s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_status <= head.status;
      s1_idx    <= head.idx;
      s1_offset <= head.offset;
      s1_prod   <= cses_pkg::PROD_W'(head.raw) * cses_pkg::PROD_W'(head.scale);
    end
  end

  // add offset and one half, truncate toward zero, saturate
  logic signed [cses_pkg::SUM_W-1:0] sum;
  logic signed [cses_pkg::QUO_W-1:0] quo;
  logic signed [cses_pkg::VAL_W-1:0] sat;

  always_comb begin
    sum = $signed({2'b00, s1_prod})
        + $signed({{(cses_pkg::SUM_W - cses_pkg::OFFSET_W - cses_pkg::FRAC_W)
                    {s1_offset[cses_pkg::OFFSET_W-1]}},
                   s1_offset, {cses_pkg::FRAC_W{1'b0}}})
        + $signed(cses_pkg::SUM_W'(1) <<< (cses_pkg::FRAC_W - 1));
    quo = sum[cses_pkg::SUM_W-1:cses_pkg::FRAC_W];
    if (sum[cses_pkg::SUM_W-1] && (sum[cses_pkg::FRAC_W-1:0] != '0)) begin
      quo = quo + 1'b1;
    end
    priority if ((quo[cses_pkg::QUO_W-1:cses_pkg::VAL_W-1] == '0) ||
                 (quo[cses_pkg::QUO_W-1:cses_pkg::VAL_W-1] == '1)) begin
      sat = quo[cses_pkg::VAL_W-1:0];
    end else if (quo[cses_pkg::QUO_W-1]) begin
      sat = {1'b1, {(cses_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(cses_pkg::VAL_W-1){1'b1}}};
    end
  end

  // statistics counters
  logic [cses_pkg::CNT_W-1:0] processed, dropped, routed;
  logic [cses_pkg::CNT_W-1:0] processed_next, dropped_next, routed_next;

  always_comb begin
    processed_next = processed;
    dropped_next   = dropped;
    routed_next    = routed;
    unique case (s1_status)
      cses_pkg::ST_CLEARED: begin
        processed_next = '0;
        dropped_next   = '0;
        routed_next    = '0;
      end
      cses_pkg::ST_ROUTED: begin
        processed_next = processed + 1'b1;
        routed_next    = routed + 1'b1;
      end
      default: begin
        processed_next = processed + 1'b1;
        dropped_next   = dropped + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      processed <= '0;
      dropped   <= '0;
      routed    <= '0;
    end else if (out_load) begin
      processed <= processed_next;
      dropped   <= dropped_next;
      routed    <= routed_next;
    end
  end

  // output register; hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (out_load) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_ch.status          <= s1_status;
      result_ch.signal_index    <= s1_idx;
      result_ch.scaled_value    <= (s1_status == cses_pkg::ST_ROUTED) ? sat : '0;
      result_ch.count_processed <= processed_next;
      result_ch.count_dropped   <= dropped_next;
      result_ch.count_routed    <= routed_next;
    end
  end

endmodule
`default_nettype wire

[tb/sv/can_signal_extract_scale_unit_test.sv]
`timescale 1ns / 100ps
module can_signal_extract_scale_unit_test;

  localparam int  HOLD_CYCLES = 120;
  localparam int  QUIET_LIMIT = 2000;
  localparam longint Q16_ONE  = 65536;
  localparam longint Q16_HALF = 32768;

  // one frame request as offered on the input channel
  typedef struct packed {
    logic        action;
    logic [28:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
  } can_frame_t;

  // one routing result as expected on the output channel
  typedef struct packed {
    cses_pkg::status_t  status;
    logic [2:0]         sig_index;
    logic signed [31:0] value;
    logic [31:0]        processed;
    logic [31:0]        dropped;
    logic [31:0]        routed;
  } signal_result_t;

  typedef struct {
    int          idx;
    logic [63:0] word;
  } table_write_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [cses_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cses_pkg::ENTRY_W-1:0]   cfg_data;

  cses_frame_if  frame_ch();
  cses_result_if result_ch();

  can_signal_extract_scale_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame_ch  (frame_ch),
    .result_ch (result_ch)
  );

  // predictor copy of the signal table and the counters
  logic [63:0] entry_tbl [cses_pkg::TABLE_ENTRIES];
  logic [31:0] pred_processed, pred_dropped, pred_routed;

  signal_result_t expected_results [$];
  table_write_t   staged_writes [$];

  bit sender_calm, sink_calm;
  int hold_orders, holds_served, hold_left;
  int mismatches, quiet_cycles;
  int frames_sent, results_seen, routed_seen, dropped_seen, cleared_seen, table_loads;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // linear scaling in Q16: round by one half, truncate toward zero, saturate
  function automatic logic signed [31:0] scale_raw(input logic [31:0] raw,
                                                   input logic [63:0] word);
    logic [19:0]        scale;
    logic signed [9:0]  offset;
    logic [51:0]        product;
    longint             sum, quo;
    scale   = word[53:34];
    offset  = word[63:54];
    product = 52'(raw) * 52'(scale);
    sum = longint'({12'd0, product}) + longint'(offset) * Q16_ONE + Q16_HALF;
    quo = sum / Q16_ONE;
    if (quo > 64'sd2147483647) quo = 64'sd2147483647;
    if (quo < -64'sd2147483648) quo = -64'sd2147483648;
    return 32'(quo);
  endfunction

  // classify one frame against the table and advance the counters
  function automatic signal_result_t route_frame(input can_frame_t f);
    signal_result_t     r;
    logic [63:0]        word;
    logic [31:0]        raw;
    cses_pkg::lencode_t lenc;
    int                 nbytes, pos, start;
    bit                 found;
    r = '0;
    r.status = cses_pkg::ST_ROUTED;
    found = 1'b0;
    raw = '0;
    if (f.action) begin
      pred_processed = '0;
      pred_dropped   = '0;
      pred_routed    = '0;
      r.status = cses_pkg::ST_CLEARED;
    end else begin
      pred_processed++;
      for (int i = 0; i < cses_pkg::TABLE_ENTRIES; i++) begin
        if (!found && entry_tbl[i][28:0] == f.id) begin
          found = 1'b1;
          r.sig_index = 3'(i);
        end
      end
      if (!found) begin
        pred_dropped++;
        r.status = cses_pkg::ST_NO_MATCH;
      end else begin
        word   = entry_tbl[r.sig_index];
        start  = int'(word[31:29]);
        lenc   = cses_pkg::lencode_t'(word[33:32]);
        nbytes = (lenc == cses_pkg::LEN_FOUR) ? 4 : int'(lenc);
        if (int'(f.dlc) < start + nbytes) begin
          pred_dropped++;
          r.status = cses_pkg::ST_DLC_SHORT;
        end else begin
          // bytes beyond position 7 read as zero
          for (int k = 0; k < nbytes; k++) begin
            pos = start + k;
            if (pos <= 7) raw[8*k +: 8] = f.data[8*pos +: 8];
          end
          r.value = scale_raw(raw, word);
          pred_routed++;
        end
      end
    end
    r.processed = pred_processed;
    r.dropped   = pred_dropped;
    r.routed    = pred_routed;
    return r;
  endfunction

  function automatic logic [63:0] pack_entry(input logic [28:0] id, input logic [2:0] start,
                                             input cses_pkg::lencode_t lenc,
                                             input logic [19:0] scale,
                                             input logic [9:0] offset);
    return {offset, scale, lenc, start, id};
  endfunction

  function automatic can_frame_t mk_frame(input logic action, input logic [28:0] id,
                                          input logic [3:0] dlc, input logic [63:0] data);
    return {action, id, dlc, data};
  endfunction

  // table entry with ids from a small pool so that frames find matches
  function automatic logic [63:0] rand_entry();
    logic [28:0] id;
    logic [2:0]  start;
    logic [19:0] scale;
    if ($urandom_range(99) < 8) return {$urandom, $urandom};
    case ($urandom_range(4))
      0:       id = 29'h100;
      1:       id = 29'h101;
      2:       id = 29'h102;
      3:       id = 29'h1FFF_FFFF;
      default: id = 29'($urandom);
    endcase
    start = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
    case ($urandom_range(3))
      0:       scale = 20'($urandom_range(65536));
      1:       scale = 20'hFFFFF;
      default: scale = 20'($urandom);
    endcase
    return pack_entry(id, start, cses_pkg::lencode_t'($urandom_range(3)), scale,
                      10'($urandom));
  endfunction

  // mostly frames aimed at table ids, some noise ids and odd DLCs, rare clears
  function automatic can_frame_t rand_frame();
    can_frame_t f;
    int         pick;
    pick = $urandom_range(99);
    f.action = (pick < 2);
    f.data   = {$urandom, $urandom};
    if (pick < 80) f.id = entry_tbl[$urandom_range(cses_pkg::TABLE_ENTRIES - 1)][28:0];
    else f.id = 29'($urandom);
    f.dlc = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    return f;
  endfunction

  // offer one request, hold it until accepted, record its expected result
  task automatic send_frame(input can_frame_t f);
    while (!sender_calm && $urandom_range(99) < 6) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.action     <= f.action;
    frame_ch.frame_id   <= f.id;
    frame_ch.frame_dlc  <= f.dlc;
    frame_ch.frame_data <= f.data;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    expected_results.push_back(route_frame(f));
    frames_sent++;
  endtask

  // drop valid and wait until every result has arrived
  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic stage_entry(input int idx, input logic [63:0] word);
    table_write_t w;
    w.idx  = idx;
    w.word = word;
    staged_writes.push_back(w);
  endtask

  // apply staged register writes once the block is idle
  task automatic load_table();
    wait_idle();
    foreach (staged_writes[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= cses_pkg::CFG_IDX_W'(staged_writes[i].idx);
      cfg_data  <= staged_writes[i].word;
      if (staged_writes[i].idx < cses_pkg::TABLE_ENTRIES)
        entry_tbl[staged_writes[i].idx] = staged_writes[i].word;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    staged_writes.delete();
    table_loads++;
  endtask

  // default table: each entry, no match, short DLC, DLC past 8, clear
  task automatic test_reset_table();
    send_frame(mk_frame(1'b0, 29'h100, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h101, 4'd8, 64'h0));
    send_frame(mk_frame(1'b0, 29'h101, 4'd4, 64'h0123_4567_89AB_CDEF));
    send_frame(mk_frame(1'b0, 29'h102, 4'd8, 64'hFEDC_BA98_7654_3210));
    send_frame(mk_frame(1'b0, 29'h102, 4'd5, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h1FFF_FFFF, 4'd8, 64'h0));
    send_frame(mk_frame(1'b0, 29'h100, 4'd0, 64'h55AA_55AA_55AA_55AA));
    send_frame(mk_frame(1'b0, 29'h101, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b1, 29'h1FFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h100, 4'd2, 64'h0000_0000_0000_1234));
  endtask

  // saturation, lowest entry wins, four bytes past the frame, rounding of negatives
  task automatic test_table_extremes();
    stage_entry(0, pack_entry(29'h7FF, 3'd0, cses_pkg::LEN_FOUR, 20'hFFFFF, 10'sd511));
    stage_entry(1, pack_entry(29'h7FF, 3'd1, cses_pkg::LEN_ONE, 20'h10000, 10'sd0));
    stage_entry(2, 64'hFFFF_FFFF_FFFF_FFFF);
    // index beyond the table must leave it untouched
    stage_entry((1 << cses_pkg::CFG_IDX_W) - 1,
                pack_entry(29'h7FF, 3'd0, cses_pkg::LEN_ONE, 20'h0, 10'h0));
    load_table();
    send_frame(mk_frame(1'b0, 29'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h7FF, 4'd4, 64'h0));
    send_frame(mk_frame(1'b0, 29'h7FF, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h1FFF_FFFF, 4'd11, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h1FFF_FFFF, 4'd10, 64'hFFFF_FFFF_FFFF_FFFF));

    stage_entry(0, pack_entry(29'h55, 3'd7, cses_pkg::LEN_NONE, 20'h0, -10'sd512));
    stage_entry(1, pack_entry(29'h3, 3'd2, cses_pkg::LEN_ONE, 20'd19661, -10'sd3));
    stage_entry(2, 64'h0);
    load_table();
    send_frame(mk_frame(1'b0, 29'h55, 4'd6, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h55, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(mk_frame(1'b0, 29'h3, 4'd3, 64'h0000_0000_0001_0000));
    send_frame(mk_frame(1'b0, 29'h3, 4'd8, 64'hFFFF_FFFF_FF00_FFFF));
    send_frame(mk_frame(1'b0, 29'h3, 4'd3, 64'h0000_0000_000A_0000));
    send_frame(mk_frame(1'b0, 29'h3, 4'd2, 64'h0000_0000_0001_0000));
    send_frame(mk_frame(1'b0, 29'h0, 4'd0, 64'h0));
  endtask

  // hold the output for a long stretch while requests keep coming
  task automatic test_stalled_output();
    hold_orders++;
    repeat (40) send_frame(rand_frame());
    wait_idle();
  endtask

  // random tables with random frames; one phase runs with no idling
  task automatic test_random_tables();
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < cses_pkg::TABLE_ENTRIES; i++) stage_entry(i, rand_entry());
      load_table();
      sender_calm = (phase == 1);
      sink_calm   = (phase == 1);
      repeat (400) send_frame(rand_frame());
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
    wait_idle();
  endtask

  // output side: random stalls plus the ordered long hold-off
  always @(posedge clk) begin
    if (hold_orders != holds_served) begin
      holds_served = hold_orders;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= sink_calm || ($urandom_range(99) >= 6);
    end
  end

  // compare each result with the oldest expectation; watch for a stuck block
  always @(posedge clk) begin : result_check
    signal_result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", result_ch.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          case (want.status)
            cses_pkg::ST_ROUTED:  routed_seen++;
            cses_pkg::ST_CLEARED: cleared_seen++;
            default:              dropped_seen++;
          endcase
          if (result_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_ch.status);
            mismatches++;
          end
          if (result_ch.signal_index !== want.sig_index) begin
            $error("signal_index: expected %0d, got %0d", want.sig_index,
                   result_ch.signal_index);
            mismatches++;
          end
          if (result_ch.scaled_value !== want.value) begin
            $error("scaled_value: expected %0d, got %0d", want.value,
                   result_ch.scaled_value);
            mismatches++;
          end
          if (result_ch.count_processed !== want.processed) begin
            $error("count_processed: expected %0d, got %0d", want.processed,
                   result_ch.count_processed);
            mismatches++;
          end
          if (result_ch.count_dropped !== want.dropped) begin
            $error("count_dropped: expected %0d, got %0d", want.dropped,
                   result_ch.count_dropped);
            mismatches++;
          end
          if (result_ch.count_routed !== want.routed) begin
            $error("count_routed: expected %0d, got %0d", want.routed,
                   result_ch.count_routed);
            mismatches++;
          end
        end
      end
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    frame_ch.valid      <= 1'b0;
    frame_ch.action     <= 1'b0;
    frame_ch.frame_id   <= '0;
    frame_ch.frame_dlc  <= '0;
    frame_ch.frame_data <= '0;
    for (int i = 0; i < cses_pkg::TABLE_ENTRIES; i++) entry_tbl[i] = cses_pkg::ENTRY_RESET[i];
    pred_processed = '0;
    pred_dropped   = '0;
    pred_routed    = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_table();
    test_table_extremes();
    test_stalled_output();
    test_random_tables();

    wait_idle();
    repeat (6) @(posedge clk);
    $display("Sent %0d frames over %0d table loads; checked %0d results", frames_sent,
             table_loads, results_seen);
    $display("  %0d routed, %0d dropped, %0d counter clears", routed_seen, dropped_seen,
             cleared_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
